// ----- rtl/core/dpb_pkg.sv -----
// Shared types and constants for the depth pixel back-projection core.
// No dependencies; used by dpb_lateral and depth_pixel_backprojection_core.
package dpb_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_Z_SCALE       = 3'd0;
  localparam logic [2:0] CFG_FOCAL_X_RECIP = 3'd1;
  localparam logic [2:0] CFG_CTR_X         = 3'd2;
  localparam logic [2:0] CFG_FOCAL_Y_RECIP = 3'd3;
  localparam logic [2:0] CFG_CTR_Y         = 3'd4;
  localparam logic [2:0] CFG_MIN_DEPTH     = 3'd5;
  localparam logic [2:0] CFG_ORGANIZED     = 3'd6;

  // Reset values
  localparam logic [23:0] RST_Z_SCALE     = 24'd16777;
  localparam logic [23:0] RST_FOCAL_RECIP = 24'd31957;
  localparam logic [15:0] RST_CTR_X       = 16'd5112;
  localparam logic [15:0] RST_CTR_Y       = 16'd3832;
  localparam logic [23:0] RST_MIN_DEPTH   = 24'd6554;  // 0.10 m

  // Signed 24-bit limits, held at the width of the lateral product
  localparam logic [35:0] SMAX24 = 36'd8388607;
  localparam logic [35:0] SMAG24 = 36'd8388608;
  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = 24'sh800000;

  typedef struct packed {
    logic [15:0] depth_raw;
    logic        mask_keep;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic        frame_last;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [23:0]        point_z;
    logic [7:0]         point_red;
    logic [7:0]         point_green;
    logic [7:0]         point_blue;
    logic               point_valid;
    logic               frame_end;
  } point_t;

  // Load enables for the pipeline stages inside the lateral unit
  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ----- rtl/core/dpb_lateral.sv -----
// Lateral coordinate pipeline: |offset| * recip, rounded, times z, saturated.
// Depends on dpb_pkg (stage_en_t, saturation limits).
module dpb_lateral (
  input  logic                clk_i,
  input  dpb_pkg::stage_en_t  en_i,
  input  logic [15:0]         mag_i,    // stage 1 offset magnitude, Q.4
  input  logic                neg_i,    // stage 1 offset sign
  input  logic [23:0]         recip_i,  // Q0.24
  input  logic [23:0]         z_i,      // stage 2 depth
  output logic signed [23:0]  coord_o   // from stage 3 registers
);

  logic [39:0] scaled;
  logic [27:0] a_d, a_q;
  logic [51:0] prod;
  logic [35:0] p_d, p_q;
  logic        neg2_q, neg3_q;

  // Q.4 * Q0.24 = Q.28, round half up to Q.16
  assign scaled = 40'(mag_i) * 40'(recip_i) + 40'd2048;
  assign a_d    = scaled[39:12];

  // Q.16 * z, round half up by 16 bits
  assign prod = 52'(a_q) * 52'(z_i) + 52'd32768;
  assign p_d  = prod[51:16];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      a_q    <= a_d;
      neg2_q <= neg_i;
    end
    if (en_i.s3) begin
      p_q    <= p_d;
      neg3_q <= neg2_q;
    end
  end

  always_comb begin
    if (neg3_q) begin
      if (p_q > dpb_pkg::SMAG24) coord_o = dpb_pkg::COORD_MIN;
      else                       coord_o = -$signed(p_q[23:0]);
    end else begin
      if (p_q > dpb_pkg::SMAX24) coord_o = dpb_pkg::COORD_MAX;
      else                       coord_o = $signed(p_q[23:0]);
    end
  end

endmodule

// ----- rtl/core/depth_pixel_backprojection_core.sv -----
// Depth pixel back-projection core: depth pixel in, camera-frame point out.
// Depends on dpb_pkg and dpb_lateral.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_item_i) carries one depth pixel
//    with its column, row, mask bit, colour and frame-last flag per item.
//  - Output channel (out_valid_o/out_ready_i/out_item_o) carries one point per
//    item. In compact mode (organized_mode = 0) items whose z comes out zero
//    give no output, except the frame's last pixel, which is always sent.
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i;
//    unknown indexes are ignored. Write only while the core is idle.
//  - Pipeline: the accepting edge loads stage 1; stages 2, 3 and the output
//    register follow in order, each loading when its successor can move on.
//    The stages are the z multiplier, the offset*recip multipliers and the
//    (offset*recip)*z multipliers; stage 1 holds one multiplier, stages 2
//    and 3 hold two each (x and y).
//  - Throughput: one item per cycle, sustained while out_ready_i stays high.
//  - Reset: clears every stage valid bit and loads the default calibration.
//  - Stall: when out_ready_i is low the output holds; upstream bubbles still
//    close up, and in_ready_o drops only once all four stages are full.
module depth_pixel_backprojection_core #(
  parameter int FRAC_BITS  = 16,  // fraction bits of point_x/y/z, 8..24
  parameter int COORD_BITS = 12   // used bits of pixel_column/row, 8..12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // config
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [23:0]     cfg_data_i,
  // pixel items in
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dpb_pkg::pixel_t in_item_i,
  // point items out
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dpb_pkg::point_t out_item_o
);

  localparam int          ZSHIFT   = 24 - FRAC_BITS;
  localparam logic [40:0] ZRND     = (41'd1 << ZSHIFT) >> 1;
  localparam logic [11:0] PIX_MASK = 12'((32'd1 << COORD_BITS) - 32'd1);

  // ---------------- configuration registers ----------------
  logic [23:0] z_scale_q, focal_x_recip_q, focal_y_recip_q, min_depth_q;
  logic [15:0] ctr_x_q, ctr_y_q;
  logic        organized_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_scale_q       <= dpb_pkg::RST_Z_SCALE;
      focal_x_recip_q <= dpb_pkg::RST_FOCAL_RECIP;
      ctr_x_q         <= dpb_pkg::RST_CTR_X;
      focal_y_recip_q <= dpb_pkg::RST_FOCAL_RECIP;
      ctr_y_q         <= dpb_pkg::RST_CTR_Y;
      min_depth_q     <= dpb_pkg::RST_MIN_DEPTH;
      organized_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpb_pkg::CFG_Z_SCALE:       z_scale_q       <= cfg_data_i;
        dpb_pkg::CFG_FOCAL_X_RECIP: focal_x_recip_q <= cfg_data_i;
        dpb_pkg::CFG_CTR_X:         ctr_x_q         <= cfg_data_i[15:0];
        dpb_pkg::CFG_FOCAL_Y_RECIP: focal_y_recip_q <= cfg_data_i;
        dpb_pkg::CFG_CTR_Y:         ctr_y_q         <= cfg_data_i[15:0];
        dpb_pkg::CFG_MIN_DEPTH:     min_depth_q     <= cfg_data_i;
        dpb_pkg::CFG_ORGANIZED:     organized_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  // Each stage loads when it is empty or its successor moves on.
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic emit3;

  assign rdy_out    = !out_valid_q || out_ready_i;
  assign rdy3       = !v3_q || rdy_out;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q        <= in_valid_i;
      if (rdy2)    v2_q        <= v1_q;
      if (rdy3)    v3_q        <= v2_q;
      if (rdy_out) out_valid_q <= v3_q && emit3;  // compact mode drops here
    end
  end

  // ---------------- stage 1: z product, pixel offsets ----------------
  logic [11:0]     col_m, row_m;
  logic [16:0]     off_x, off_y, negx_off, negy_off;
  dpb_pkg::pixel_t pix1_q, pix2_q, pix3_q;
  logic [39:0]     prod1_q;
  logic [15:0]     mag_x1_q, mag_y1_q;
  logic            neg_x1_q, neg_y1_q;

  assign col_m    = in_item_i.pixel_column & PIX_MASK;
  assign row_m    = in_item_i.pixel_row & PIX_MASK;
  assign off_x    = {1'b0, col_m, 4'b0000} - {1'b0, ctr_x_q};
  assign off_y    = {1'b0, row_m, 4'b0000} - {1'b0, ctr_y_q};
  assign negx_off = -off_x;
  assign negy_off = -off_y;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pix1_q   <= in_item_i;
      prod1_q  <= 40'(in_item_i.depth_raw) * 40'(z_scale_q);
      neg_x1_q <= off_x[16];
      neg_y1_q <= off_y[16];
      mag_x1_q <= off_x[16] ? negx_off[15:0] : off_x[15:0];
      mag_y1_q <= off_y[16] ? negy_off[15:0] : off_y[15:0];
    end
  end

  // ---------------- stage 2: round/saturate z, depth gate ----------------
  logic [40:0] zsum, zshift;
  logic [23:0] zr, z2_q, z3_q;
  logic        ok2, val2_q, val3_q;

  assign zsum   = {1'b0, prod1_q} + ZRND;
  assign zshift = zsum >> ZSHIFT;
  assign zr     = (|zshift[40:24]) ? 24'hFFFFFF : zshift[23:0];
  assign ok2    = pix1_q.mask_keep && (zr >= min_depth_q);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pix2_q <= pix1_q;
      z2_q   <= ok2 ? zr : 24'd0;
      val2_q <= ok2;
    end
    if (rdy3) begin
      pix3_q <= pix2_q;
      z3_q   <= z2_q;
      val3_q <= val2_q;
    end
  end

  // ---------------- stages 2-3: lateral coordinates ----------------
  dpb_pkg::stage_en_t lat_en;
  logic signed [23:0] x3, y3;

  assign lat_en.s2 = rdy2;
  assign lat_en.s3 = rdy3;

  dpb_lateral u_lat_x (
    .clk_i   (clk_i),
    .en_i    (lat_en),
    .mag_i   (mag_x1_q),
    .neg_i   (neg_x1_q),
    .recip_i (focal_x_recip_q),
    .z_i     (z2_q),
    .coord_o (x3)
  );

  dpb_lateral u_lat_y (
    .clk_i   (clk_i),
    .en_i    (lat_en),
    .mag_i   (mag_y1_q),
    .neg_i   (neg_y1_q),
    .recip_i (focal_y_recip_q),
    .z_i     (z2_q),
    .coord_o (y3)
  );

  // ---------------- output register ----------------
  dpb_pkg::point_t pt3, out_q;

  always_comb begin
    pt3.point_x     = val3_q ? x3 : 24'sd0;
    pt3.point_y     = val3_q ? y3 : 24'sd0;
    pt3.point_z     = z3_q;
    pt3.point_red   = pix3_q.pixel_red;
    pt3.point_green = pix3_q.pixel_green;
    pt3.point_blue  = pix3_q.pixel_blue;
    pt3.point_valid = val3_q;
    pt3.frame_end   = pix3_q.frame_last;
  end

  // zero-z points vanish in compact mode, the frame marker never does
  assign emit3 = organized_q || (z3_q != 24'd0) || pix3_q.frame_last;

  always_ff @(posedge clk_i) begin
    if (rdy_out) out_q <= pt3;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------- assertions ----------------
  // input backs up only with every stage occupied
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && out_valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // a zeroed point carries no coordinates
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.point_valid) |->
      (out_q.point_x == 24'sd0 && out_q.point_y == 24'sd0 && out_q.point_z == 24'd0))
    else $error("invalid point has nonzero coordinates");

  // a real point is never shallower than the limit
  a_min_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.point_valid) |-> (out_q.point_z >= min_depth_q))
    else $error("valid point below min depth");

  // compact mode passes a zero-z point only as the frame marker
  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !organized_q && out_q.point_z == 24'd0) |-> out_q.frame_end)
    else $error("zero point leaked in compact mode");

endmodule

// ----- verif/point_checker.sv -----
// Scoreboard for the depth pixel back-projection core: predicts each point from
// the accepted pixel items and a shadow of the calibration, then compares.
// Depends on dpb_pkg.
module point_checker #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [23:0]     cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  dpb_pkg::pixel_t in_item_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  dpb_pkg::point_t out_item_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int          Z_SHIFT  = 24 - FRAC_BITS;
  localparam logic [63:0] Z_HALF   = (64'd1 << Z_SHIFT) >> 1;
  localparam logic [11:0] PIX_MASK = 12'((1 << COORD_BITS) - 1);

  // shadow calibration
  logic [23:0] z_scale_q;
  logic [23:0] focal_x_q;
  logic [15:0] ctr_x_q;
  logic [23:0] focal_y_q;
  logic [15:0] ctr_y_q;
  logic [23:0] min_depth_q;
  logic        organized_q;

  dpb_pkg::point_t expected_points[$];
  dpb_pkg::point_t predicted;
  dpb_pkg::point_t oldest;
  int              fails = 0;

  assign fail_count_o = fails;

  // offset from the optical centre scaled by 1/f and by z, rounded half away
  // from zero and saturated to signed 24 bits
  function automatic logic [23:0] lateral_coord(input logic [11:0] pix,
                                                input logic [15:0] centre,
                                                input logic [23:0] recip,
                                                input logic [23:0] z);
    logic signed [18:0] offset;
    logic [63:0] mag;
    logic [63:0] per_pixel;
    logic [63:0] scaled;
    offset = $signed({3'b000, pix & PIX_MASK, 4'b0000}) - $signed({3'b000, centre});
    mag = (offset < 0) ? 64'(-offset) : 64'(offset);
    per_pixel = (mag * 64'(recip) + 64'd2048) >> 12;
    scaled = (per_pixel * 64'(z) + 64'd32768) >> 16;
    if (offset < 0) begin
      return (scaled > 64'(dpb_pkg::SMAG24)) ? dpb_pkg::COORD_MIN : 24'(-scaled);
    end
    return (scaled > 64'(dpb_pkg::SMAX24)) ? dpb_pkg::COORD_MAX : scaled[23:0];
  endfunction

  // returns 0 when compact mode drops the point
  function automatic bit project_pixel(input dpb_pkg::pixel_t px,
                                       output dpb_pkg::point_t pt);
    logic [63:0] z_full;
    logic [23:0] z;
    pt = '0;
    z = '0;
    if (px.mask_keep) begin
      z_full = (64'(px.depth_raw) * 64'(z_scale_q) + Z_HALF) >> Z_SHIFT;
      if (z_full > 64'hFFFFFF) z_full = 64'hFFFFFF;
      if (z_full[23:0] >= min_depth_q) begin
        z = z_full[23:0];
        pt.point_x = lateral_coord(px.pixel_column, ctr_x_q, focal_x_q, z);
        pt.point_y = lateral_coord(px.pixel_row, ctr_y_q, focal_y_q, z);
        pt.point_valid = 1'b1;
      end
    end
    pt.point_z = z;
    pt.point_red = px.pixel_red;
    pt.point_green = px.pixel_green;
    pt.point_blue = px.pixel_blue;
    pt.frame_end = px.frame_last;
    return !(!organized_q && z == '0 && !px.frame_last);
  endfunction

  task automatic compare_field(input string field, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_scale_q   <= dpb_pkg::RST_Z_SCALE;
      focal_x_q   <= dpb_pkg::RST_FOCAL_RECIP;
      ctr_x_q     <= dpb_pkg::RST_CTR_X;
      focal_y_q   <= dpb_pkg::RST_FOCAL_RECIP;
      ctr_y_q     <= dpb_pkg::RST_CTR_Y;
      min_depth_q <= dpb_pkg::RST_MIN_DEPTH;
      organized_q <= 1'b1;
      expected_points.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dpb_pkg::CFG_Z_SCALE:       z_scale_q   <= cfg_data_i;
          dpb_pkg::CFG_FOCAL_X_RECIP: focal_x_q   <= cfg_data_i;
          dpb_pkg::CFG_CTR_X:         ctr_x_q     <= cfg_data_i[15:0];
          dpb_pkg::CFG_FOCAL_Y_RECIP: focal_y_q   <= cfg_data_i;
          dpb_pkg::CFG_CTR_Y:         ctr_y_q     <= cfg_data_i[15:0];
          dpb_pkg::CFG_MIN_DEPTH:     min_depth_q <= cfg_data_i;
          dpb_pkg::CFG_ORGANIZED:     organized_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (project_pixel(in_item_i, predicted)) expected_points = {expected_points, predicted};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: point with none outstanding, expected none, actual %h",
                   $time, out_item_i);
          fails++;
        end else begin
          oldest = expected_points.pop_front();
          compare_field("point_x", oldest.point_x, out_item_i.point_x);
          compare_field("point_y", oldest.point_y, out_item_i.point_y);
          compare_field("point_z", oldest.point_z, out_item_i.point_z);
          compare_field("point_red", 24'(oldest.point_red), 24'(out_item_i.point_red));
          compare_field("point_green", 24'(oldest.point_green), 24'(out_item_i.point_green));
          compare_field("point_blue", 24'(oldest.point_blue), 24'(out_item_i.point_blue));
          compare_field("point_valid", 24'(oldest.point_valid), 24'(out_item_i.point_valid));
          compare_field("frame_end", 24'(oldest.frame_end), 24'(out_item_i.frame_end));
        end
      end
      pending_o <= expected_points.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Testbench top for depth_pixel_backprojection_core: clock, reset, calibration
// writes, pixel stimulus and output stalls; point_checker does the comparing.
// Depends on dpb_pkg, depth_pixel_backprojection_core and point_checker.
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;    // pipeline is 4 deep, doubled
  localparam int PHASE_ITEMS  = 255;
  localparam int HOLD_CYCLES  = 100;  // long receiver hold-off
  localparam logic [2:0] CFG_UNMAPPED = 3'd7;

  // one full calibration setting
  typedef struct packed {
    logic [23:0] z_scale;
    logic [23:0] focal_x_recip;
    logic [15:0] ctr_x;
    logic [23:0] focal_y_recip;
    logic [15:0] ctr_y;
    logic [23:0] min_depth;
    logic        organized;
  } calib_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_idx = '0;
  logic [23:0]     cfg_data = '0;
  logic            in_valid = 1'b0;
  dpb_pkg::pixel_t in_item = '0;
  logic            out_ready = 1'b0;
  logic            in_ready;
  logic            out_valid;
  dpb_pkg::point_t out_item;

  int     fail_count;
  int     pending;
  int     cycle_count = 0;
  bit     hold_request = 1'b0;  // stimulus asks the receiver for a long stall

  depth_pixel_backprojection_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  point_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a point never shows up or the input hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver: segments of random length, each with its own ready pattern
  // (always ready, coin flip, mostly stalled, periodic). A hold request from
  // the stimulus overrides the pattern for HOLD_CYCLES so the core backs up.
  initial begin : receiver
    int unsigned mode;
    int unsigned seg_left;
    int unsigned hold_left;
    mode = 0;
    seg_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 80);
      end
      seg_left--;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (seg_left % 5 != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted. Valid stays high on return so
  // a following item goes out back to back.
  task automatic send_pixel(input dpb_pkg::pixel_t px);
    in_item <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes every register, then a junk write to the unmapped index last so
  // that any decode aliasing would clobber the setting just made.
  task automatic load_calib(input calib_t c);
    write_reg(dpb_pkg::CFG_Z_SCALE, c.z_scale);
    write_reg(dpb_pkg::CFG_FOCAL_X_RECIP, c.focal_x_recip);
    write_reg(dpb_pkg::CFG_CTR_X, 24'(c.ctr_x));
    write_reg(dpb_pkg::CFG_FOCAL_Y_RECIP, c.focal_y_recip);
    write_reg(dpb_pkg::CFG_CTR_Y, 24'(c.ctr_y));
    write_reg(dpb_pkg::CFG_MIN_DEPTH, c.min_depth);
    write_reg(dpb_pkg::CFG_ORGANIZED, 24'(c.organized));
    write_reg(CFG_UNMAPPED, 24'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected point, then let dropped items flush.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic dpb_pkg::pixel_t make_item(input logic [15:0] depth,
                                                input logic keep,
                                                input logic [11:0] col,
                                                input logic [11:0] row,
                                                input logic [7:0] shade,
                                                input logic last);
    dpb_pkg::pixel_t px;
    px.depth_raw = depth;
    px.mask_keep = keep;
    px.pixel_column = col;
    px.pixel_row = row;
    px.pixel_red = shade;
    px.pixel_green = ~shade;
    px.pixel_blue = shade;
    px.frame_last = last;
    return px;
  endfunction

  // Random pixel. Depth leans toward zero, full scale, small values and the
  // min-depth threshold; coordinates sometimes cluster around the centre so
  // the offset changes sign.
  function automatic dpb_pkg::pixel_t random_pixel(input calib_t c,
                                                   input int unsigned last_odds);
    dpb_pkg::pixel_t px;
    logic [63:0] d;
    px.depth_raw = 16'($urandom);
    case ($urandom_range(0, 7))
      0: px.depth_raw = 16'd0;
      1: px.depth_raw = 16'hFFFF;
      2: begin
        if (c.z_scale != '0) begin
          d = (64'(c.min_depth) << 8) / 64'(c.z_scale) + 64'($urandom_range(0, 4));
          d = (d < 2) ? 64'd0 : d - 2;
          px.depth_raw = (d > 64'hFFFF) ? 16'hFFFF : d[15:0];
        end
      end
      3: px.depth_raw = 16'($urandom_range(0, 255));
      default: ;
    endcase
    px.mask_keep = ($urandom_range(0, 7) != 0);
    px.pixel_column = ($urandom_range(0, 3) == 0) ?
        c.ctr_x[15:4] + 12'($urandom_range(0, 4)) - 12'd2 : 12'($urandom);
    px.pixel_row = ($urandom_range(0, 3) == 0) ?
        c.ctr_y[15:4] + 12'($urandom_range(0, 4)) - 12'd2 : 12'($urandom);
    px.pixel_red = 8'($urandom);
    px.pixel_green = 8'($urandom);
    px.pixel_blue = 8'($urandom);
    px.frame_last = ($urandom_range(0, last_odds - 1) == 0);
    return px;
  endfunction

  function automatic calib_t realistic_calib(input logic organized);
    calib_t c;
    c.z_scale = 24'($urandom_range(1000, 40000));
    c.focal_x_recip = 24'($urandom_range(10000, 100000));
    c.ctr_x = 16'($urandom_range(1600, 16000));
    c.focal_y_recip = 24'($urandom_range(10000, 100000));
    c.ctr_y = 16'($urandom_range(1600, 16000));
    c.min_depth = 24'($urandom_range(0, 70000));
    c.organized = organized;
    return c;
  endfunction

  function automatic calib_t wild_calib();
    calib_t c;
    c.z_scale = 24'($urandom);
    c.focal_x_recip = 24'($urandom);
    c.ctr_x = 16'($urandom);
    c.focal_y_recip = 24'($urandom);
    c.ctr_y = 16'($urandom);
    c.min_depth = 24'($urandom);
    c.organized = 1'($urandom);
    return c;
  endfunction

  // Random phase: bursts of random length with random gaps, sometimes none.
  // With pressure, halfway through the receiver is told to hold off while a
  // long gapless burst keeps coming, so the core fills and drops in_ready.
  task automatic run_random_phase(input calib_t c, input int unsigned last_odds,
                                  input bit with_pressure);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit pressed;
    sent = 0;
    pressed = 1'b0;
    load_calib(c);
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 24);
      if (with_pressure && !pressed && sent >= PHASE_ITEMS / 2) begin
        hold_request = 1'b1;
        pressed = 1'b1;
        burst = 40;
      end
      for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
        send_pixel(random_pixel(c, last_odds));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (sent < PHASE_ITEMS && gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    wait_idle();
  endtask

  initial begin : stimulus
    calib_t c;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset calibration, organized mode: every pixel gives a point.
    send_pixel(make_item(16'd0, 1'b1, 12'd0, 12'd0, 8'h00, 1'b0));        // zero depth
    send_pixel(make_item(16'hFFFF, 1'b1, 12'd0, 12'd0, 8'hFF, 1'b0));     // far corner
    send_pixel(make_item(16'hFFFF, 1'b1, 12'hFFF, 12'hFFF, 8'h00, 1'b0)); // other corner
    send_pixel(make_item(16'hFFFF, 1'b0, 12'd100, 12'd100, 8'hFF, 1'b0)); // masked
    send_pixel(make_item(16'd99, 1'b1, 12'd320, 12'd240, 8'h12, 1'b0));   // just too shallow
    send_pixel(make_item(16'd100, 1'b1, 12'd320, 12'd240, 8'h34, 1'b0));  // right at min
    send_pixel(make_item(16'd2000, 1'b1, 12'd319, 12'd239, 8'h56, 1'b0)); // near centre
    send_pixel(make_item(16'd1500, 1'b1, 12'd640, 12'd480, 8'h78, 1'b1)); // frame end
    send_pixel(make_item(16'd0, 1'b0, 12'hFFF, 12'd0, 8'h9A, 1'b1));      // masked, frame end
    send_pixel(make_item(16'hAAAA, 1'b1, 12'h555, 12'hAAA, 8'h55, 1'b0));
    send_pixel(make_item(16'h5555, 1'b1, 12'hAAA, 12'h555, 8'hAA, 1'b1));
    wait_idle();

    // Directed, extreme calibration, compact mode, min depth 0: saturation in
    // both directions, zero-z valid points dropped unless they end the frame.
    c = '{z_scale: 24'hFFFFFF, focal_x_recip: 24'hFFFFFF, ctr_x: 16'hFFFF,
          focal_y_recip: 24'hFFFFFF, ctr_y: 16'h0000, min_depth: 24'd0,
          organized: 1'b0};
    load_calib(c);
    send_pixel(make_item(16'd0, 1'b1, 12'd0, 12'd0, 8'h11, 1'b0));        // dropped
    send_pixel(make_item(16'd0, 1'b1, 12'd0, 12'd0, 8'h22, 1'b1));        // frame marker
    send_pixel(make_item(16'hFFFF, 1'b1, 12'd0, 12'hFFF, 8'h33, 1'b0));   // x low, y high
    send_pixel(make_item(16'hFFFF, 1'b0, 12'd7, 12'd7, 8'h44, 1'b0));     // masked, dropped
    send_pixel(make_item(16'hFFFF, 1'b0, 12'd7, 12'd7, 8'h55, 1'b1));     // masked marker
    send_pixel(make_item(16'd1, 1'b1, 12'hFFF, 12'd0, 8'h66, 1'b0));      // small offset
    wait_idle();

    // min depth at full scale: only a saturated z survives
    c.min_depth = 24'hFFFFFF;
    load_calib(c);
    send_pixel(make_item(16'd256, 1'b1, 12'd10, 12'd20, 8'h77, 1'b0));    // z exactly max
    send_pixel(make_item(16'd255, 1'b1, 12'd10, 12'd20, 8'h88, 1'b1));    // one step short
    wait_idle();

    run_random_phase(realistic_calib(1'b1), 16, 1'b1);
    run_random_phase(realistic_calib(1'b0), 16, 1'b0);
    run_random_phase(wild_calib(), 8, 1'b0);
    // all zero: every z is 0, so in compact mode only frame markers come out
    run_random_phase('{z_scale: 24'd0, focal_x_recip: 24'd0, ctr_x: 16'd0,
                       focal_y_recip: 24'd0, ctr_y: 16'd0, min_depth: 24'd0,
                       organized: 1'b0}, 4, 1'b0);
    run_random_phase('{z_scale: 24'hFFFFFF, focal_x_recip: 24'hFFFFFF,
                       ctr_x: 16'hFFFF, focal_y_recip: 24'hFFFFFF,
                       ctr_y: 16'hFFFF, min_depth: 24'hFFFFFF,
                       organized: 1'b1}, 16, 1'b0);
    run_random_phase('{z_scale: 24'hFFFFFF, focal_x_recip: 24'hFFFFFF,
                       ctr_x: 16'h0000, focal_y_recip: 24'hFFFFFF,
                       ctr_y: 16'hFFFF, min_depth: 24'd0,
                       organized: 1'b0}, 16, 1'b0);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
